/* hdl/kti_pkg.sv */
// Package for the keyframe trajectory interpolator.
// Holds the opcode and status codes, the lane control struct and the stamp scaling helper.
// No dependencies.
`default_nettype none
package kti_pkg;

   localparam int JOINTS_MAX = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_TOL  = 2'd1;

   localparam logic [3:0] ST_LOADED    = 4'd0;
   localparam logic [3:0] ST_FULL      = 4'd1;
   localparam logic [3:0] ST_CLEARED   = 4'd2;
   localparam logic [3:0] ST_EXACT     = 4'd3;
   localparam logic [3:0] ST_INTERP    = 4'd4;
   localparam logic [3:0] ST_CLAMP_END = 4'd5;
   localparam logic [3:0] ST_CLAMP_BEG = 4'd6;
   localparam logic [3:0] ST_EMPTY     = 4'd7;
   localparam logic [3:0] ST_ORDER     = 4'd8;

   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      logic        cap_a;
      logic        start;
      logic [31:0] off;
      logic [31:0] delta;
   } lane_ctl_type;

   // Q8.8 product >> 8, saturated to 32 bits
   function automatic logic [31:0] scale_sat(input logic [47:0] prod);
      logic [31:0] res;
      res = (prod[47:40] != 8'd0) ? 32'hFFFF_FFFF : prod[39:8];
      return res;
   endfunction

endpackage
`default_nettype wire

/* hdl/kti_lane.sv */
// One joint lane: keyframe store for the joint plus a serial multiply-divide unit.
// Depends on kti_pkg.
`default_nettype none
module kti_lane #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire kti_pkg::lane_ctl_type ctl,
   input  wire logic [ADDR_W-1:0]    addr,
   input  wire logic [31:0]          wr_data,
   output logic [31:0]               result,
   output logic                      busy
);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_MUL  = 2'd1;
   localparam logic [1:0] L_DIV  = 2'd2;
   localparam logic [1:0] L_FIN  = 2'd3;

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_q_ff;
   logic [31:0] a_ff;
   logic [31:0] res_ff;
   logic [31:0] delta_ff;
   logic [31:0] rem_ff;
   logic [32:0] mag_ff;
   logic        neg_ff;
   logic [65:0] acc_ff;
   logic [6:0]  cnt_ff;
   logic [1:0]  phase_ff;

   logic [32:0] diff;
   logic [33:0] mul_sum;
   logic [32:0] div_rs;
   logic        div_ge;
   logic [32:0] quot;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[addr];
      end
   end

   assign diff    = {rd_q_ff[31], rd_q_ff} - {a_ff[31], a_ff};
   assign mul_sum = acc_ff[65:32] + (acc_ff[0] ? {1'b0, mag_ff} : 34'd0);
   assign div_rs  = {rem_ff, acc_ff[64]};
   assign div_ge  = div_rs >= {1'b0, delta_ff};
   assign quot    = acc_ff[32:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= L_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (phase_ff)
            L_IDLE: begin
               if (ctl.start) begin
                  phase_ff <= L_MUL;
                  cnt_ff   <= '0;
               end
            end
            L_MUL: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd31) begin
                  phase_ff <= L_DIV;
                  cnt_ff   <= '0;
               end
            end
            L_DIV: begin
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd64) begin
                  phase_ff <= L_FIN;
               end
            end
            L_FIN: begin
               phase_ff <= L_IDLE;
            end
            default: phase_ff <= L_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cap_a) begin
         a_ff   <= rd_q_ff;
         res_ff <= rd_q_ff;
      end
      if (ctl.start) begin
         neg_ff   <= diff[32];
         mag_ff   <= diff[32] ? (33'd0 - diff) : diff;
         delta_ff <= ctl.delta;
         acc_ff   <= {34'd0, ctl.off};
         rem_ff   <= '0;
      end
      if (phase_ff == L_MUL) begin
         acc_ff <= {1'b0, mul_sum, acc_ff[31:1]};
      end
      if (phase_ff == L_DIV) begin
         rem_ff        <= div_ge ? 32'(div_rs - {1'b0, delta_ff}) : div_rs[31:0];
         acc_ff[64:0]  <= {acc_ff[63:0], div_ge};
      end
      if (phase_ff == L_FIN) begin
         res_ff <= neg_ff ? 32'({a_ff[31], a_ff} - quot) : 32'({a_ff[31], a_ff} + quot);
      end
   end

   assign result = res_ff;
   assign busy   = phase_ff != L_IDLE;

endmodule
`default_nettype wire

/* hdl/keyframe_trajectory_interpolator_top.sv */
// Top level of the keyframe trajectory interpolator: control sequencer, stamp store,
// shared stamp scaler and the result register. Depends on kti_pkg and kti_lane.
`default_nettype none
// Usage
//  - req_ channel: one transaction carries an opcode (clear, append, query), a path,
//    a time value and six joint positions. Taken only while the sequencer is idle.
//  - rsp_ channel: exactly one transaction per request: status, six joints, duration.
//  - csr_ port: write time_scale (index 0) or match_tolerance (index 1) while idle.
//  - Transaction time: a query grows with the keyframes scanned, and interpolating
//    adds the serial multiply-divide in each joint lane (32 multiply steps, 65 divide
//    steps). That unit and the single-read stamp memory set the transaction time.
//  - All joint lanes run their divide together; the result register merges them.
//  - Reset clears the keyframe counts, restores the registers to their reset values
//    and drops any pending response. Stamp and joint stores are not cleared.
//  - A stalled receiver holds the response register; the next request may be taken
//    meanwhile and its result waits until the register is free.
module keyframe_trajectory_interpolator_top #(
   parameter int NUM_PATHS     = 4,
   parameter int MAX_KEYFRAMES = 256,
   parameter int NUM_JOINTS    = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [1:0]  req_path_index,
   input  wire logic [31:0] req_time_value,
   input  wire logic [31:0] req_joint_0,
   input  wire logic [31:0] req_joint_1,
   input  wire logic [31:0] req_joint_2,
   input  wire logic [31:0] req_joint_3,
   input  wire logic [31:0] req_joint_4,
   input  wire logic [31:0] req_joint_5,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_status,
   output logic [31:0]      rsp_out_joint_0,
   output logic [31:0]      rsp_out_joint_1,
   output logic [31:0]      rsp_out_joint_2,
   output logic [31:0]      rsp_out_joint_3,
   output logic [31:0]      rsp_out_joint_4,
   output logic [31:0]      rsp_out_joint_5,
   output logic [31:0]      rsp_path_duration,
   input  wire logic        csr_we,
   input  wire logic [kti_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kti_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH   = NUM_PATHS * MAX_KEYFRAMES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(MAX_KEYFRAMES + 1);
   localparam int PIDX_W  = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
   localparam int NJ      = kti_pkg::JOINTS_MAX;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_APP_RD  = 4'd1;
   localparam logic [3:0] S_APP_CHK = 4'd2;
   localparam logic [3:0] S_APP_WR  = 4'd3;
   localparam logic [3:0] S_Q_RDL   = 4'd4;
   localparam logic [3:0] S_Q_RDF   = 4'd5;
   localparam logic [3:0] S_Q_DUR   = 4'd6;
   localparam logic [3:0] S_Q_DURW  = 4'd7;
   localparam logic [3:0] S_SC_RD   = 4'd8;
   localparam logic [3:0] S_SC_MUL  = 4'd9;
   localparam logic [3:0] S_SC_CMP  = 4'd10;
   localparam logic [3:0] S_LN_RDA  = 4'd11;
   localparam logic [3:0] S_LN_RDB  = 4'd12;
   localparam logic [3:0] S_LN_GO   = 4'd13;
   localparam logic [3:0] S_LN_RUN  = 4'd14;
   localparam logic [3:0] S_DONE    = 4'd15;

   logic [3:0]        state_ff, state_in;
   logic [15:0]       scale_ff;
   logic [15:0]       tol_ff;
   logic [CNT_W-1:0]  cnt_ff [NUM_PATHS];
   logic [1:0]        path_ff;
   logic [31:0]       t_ff;
   logic [31:0]       jin_ff [NJ];
   logic [CNT_W-1:0]  idx_ff;
   logic [31:0]       last_ff;
   logic [31:0]       sp_ff;
   logic [31:0]       dur_ff;
   logic [3:0]        status_ff;
   logic              use_lanes_ff;
   logic [31:0]       off_ff;
   logic [31:0]       delta_ff;
   logic [31:0]       tmem [DEPTH];
   logic [31:0]       tq_ff;
   logic [47:0]       prod_ff;
   logic              rsp_valid_ff;
   logic [3:0]        rsp_status_ff;
   logic [31:0]       rsp_joint_ff [NJ];
   logic [31:0]       rsp_dur_ff;

   logic [PIDX_W-1:0] pidx;
   logic              path_ok;
   logic [CNT_W-1:0]  cnt_rd;
   logic [PIDX_W-1:0] req_pidx;
   logic              req_path_ok;
   logic [CNT_W-1:0]  req_cnt;
   logic [ADDR_W-1:0] base;
   logic [ADDR_W-1:0] addr;
   logic              t_rd;
   logic              t_wr;
   logic [31:0]       mul_a;
   logic [31:0]       s_now;
   logic              go_interp;
   logic              lane_busy_any;
   logic [31:0]       jreq [NJ];
   logic [31:0]       lane_res [NJ];
   logic [NJ-1:0]     lane_busy;
   kti_pkg::lane_ctl_type lane_ctl;

   assign jreq[0] = req_joint_0;
   assign jreq[1] = req_joint_1;
   assign jreq[2] = req_joint_2;
   assign jreq[3] = req_joint_3;
   assign jreq[4] = req_joint_4;
   assign jreq[5] = req_joint_5;

   assign pidx    = PIDX_W'({{PIDX_W{1'b0}}, path_ff});
   assign path_ok = 32'(path_ff) < NUM_PATHS;
   assign cnt_rd  = path_ok ? cnt_ff[pidx] : '0;
   // keyframe count of the path named by the incoming request
   assign req_pidx    = PIDX_W'({{PIDX_W{1'b0}}, req_path_index});
   assign req_path_ok = 32'(req_path_index) < NUM_PATHS;
   assign req_cnt     = req_path_ok ? cnt_ff[req_pidx] : '0;
   assign base    = ADDR_W'(32'(pidx) * MAX_KEYFRAMES);
   assign s_now   = kti_pkg::scale_sat(prod_ff);
   assign go_interp = (s_now >= t_ff) && !((s_now - t_ff) < 32'(tol_ff))
                      && (idx_ff != '0);
   assign lane_busy_any = |lane_busy;
   assign req_ready = state_ff == S_IDLE;

   // address and port controls per sequencer state
   always_comb begin
      addr     = base + ADDR_W'(idx_ff);
      t_rd     = 1'b0;
      t_wr     = 1'b0;
      mul_a    = tq_ff;
      lane_ctl = '{wr_en: 1'b0, rd_en: 1'b0, cap_a: 1'b0, start: 1'b0,
                   off: off_ff, delta: delta_ff};
      unique case (state_ff)
         S_APP_RD, S_Q_RDL: begin
            addr = base + ADDR_W'(cnt_rd - CNT_W'(1));
            t_rd = 1'b1;
         end
         S_APP_WR: begin
            addr = base + ADDR_W'(cnt_rd);
            t_wr = 1'b1;
            lane_ctl.wr_en = 1'b1;
         end
         S_Q_RDF: begin
            addr = base;
            t_rd = 1'b1;
         end
         S_Q_DUR: mul_a = last_ff - tq_ff;
         S_SC_RD: begin
            t_rd = 1'b1;
            lane_ctl.rd_en = 1'b1;
         end
         S_SC_MUL: lane_ctl.cap_a = 1'b1;
         S_LN_RDA: begin
            addr = base + ADDR_W'(idx_ff - CNT_W'(1));
            lane_ctl.rd_en = 1'b1;
         end
         S_LN_RDB: begin
            lane_ctl.rd_en = 1'b1;
            lane_ctl.cap_a = 1'b1;
         end
         S_LN_GO: lane_ctl.start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (t_wr) begin
         tmem[addr] <= t_ff;
      end
      if (t_rd) begin
         tq_ff <= tmem[addr];
      end
      prod_ff <= mul_a * scale_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            // decode of an accepted transaction
            if (req_valid) begin
               state_in = S_DONE;
               priority if (req_opcode == kti_pkg::OP_CLEAR) begin
                  state_in = S_DONE;
               end else if (req_opcode == kti_pkg::OP_APPEND) begin
                  if (req_path_ok && req_cnt == '0) begin
                     state_in = S_APP_WR;
                  end else if (req_path_ok && 32'(req_cnt) < MAX_KEYFRAMES) begin
                     state_in = S_APP_RD;
                  end
               end else begin
                  if (req_cnt != '0) begin
                     state_in = S_Q_RDL;
                  end
               end
            end
         end
         S_APP_RD:  state_in = S_APP_CHK;
         S_APP_CHK: state_in = (t_ff < tq_ff) ? S_DONE : S_APP_WR;
         S_APP_WR:  state_in = S_DONE;
         S_Q_RDL:   state_in = S_Q_RDF;
         S_Q_RDF:   state_in = S_Q_DUR;
         S_Q_DUR:   state_in = S_Q_DURW;
         S_Q_DURW:  state_in = S_SC_RD;
         S_SC_RD:   state_in = S_SC_MUL;
         S_SC_MUL:  state_in = S_SC_CMP;
         S_SC_CMP: begin
            if (t_ff > s_now) begin
               state_in = ((idx_ff + CNT_W'(1)) == cnt_rd) ? S_DONE : S_SC_RD;
            end else begin
               state_in = go_interp ? S_LN_RDA : S_DONE;
            end
         end
         S_LN_RDA:  state_in = S_LN_RDB;
         S_LN_RDB:  state_in = S_LN_GO;
         S_LN_GO:   state_in = S_LN_RUN;
         S_LN_RUN:  state_in = lane_busy_any ? S_LN_RUN : S_DONE;
         S_DONE:    state_in = (!rsp_valid_ff || rsp_ready) ? S_IDLE : S_DONE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scale_ff     <= 16'd256;
         tol_ff       <= 16'd1;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_PATHS; p++) begin
            cnt_ff[p] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == kti_pkg::CSR_TIME_SCALE) begin
            scale_ff <= csr_wdata;
         end
         if (csr_we && csr_index == kti_pkg::CSR_MATCH_TOL) begin
            tol_ff <= csr_wdata;
         end
         priority if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_APP_WR) begin
            cnt_ff[pidx] <= cnt_rd + CNT_W'(1);
         end
         if (req_valid && req_ready && req_opcode == kti_pkg::OP_CLEAR) begin
            for (int p = 0; p < NUM_PATHS; p++) begin
               cnt_ff[p] <= '0;
            end
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         path_ff      <= req_path_index;
         t_ff         <= req_time_value;
         dur_ff       <= '0;
         use_lanes_ff <= 1'b0;
         for (int j = 0; j < NJ; j++) begin
            jin_ff[j] <= jreq[j];
         end
         priority if (req_opcode == kti_pkg::OP_CLEAR) begin
            status_ff <= kti_pkg::ST_CLEARED;
         end else if (req_opcode == kti_pkg::OP_APPEND) begin
            status_ff <= kti_pkg::ST_FULL;
         end else begin
            status_ff <= kti_pkg::ST_EMPTY;
         end
      end
      unique case (state_ff)
         S_APP_CHK: status_ff <= (t_ff < tq_ff) ? kti_pkg::ST_ORDER : kti_pkg::ST_LOADED;
         S_APP_WR:  status_ff <= kti_pkg::ST_LOADED;
         S_Q_RDF:   last_ff <= tq_ff;
         S_Q_DURW: begin
            dur_ff <= s_now;
            idx_ff <= '0;
         end
         S_SC_CMP: begin
            use_lanes_ff <= 1'b1;
            if (t_ff > s_now) begin
               sp_ff     <= s_now;
               idx_ff    <= idx_ff + CNT_W'(1);
               status_ff <= kti_pkg::ST_CLAMP_END;
            end else if ((s_now - t_ff) < 32'(tol_ff)) begin
               status_ff <= kti_pkg::ST_EXACT;
            end else if (idx_ff == '0) begin
               status_ff <= kti_pkg::ST_CLAMP_BEG;
            end else begin
               status_ff <= kti_pkg::ST_INTERP;
               delta_ff  <= s_now - sp_ff;
               off_ff    <= t_ff - sp_ff;
            end
         end
         default: ;
      endcase
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_status_ff <= status_ff;
         rsp_dur_ff    <= dur_ff;
         for (int j = 0; j < NJ; j++) begin
            rsp_joint_ff[j] <= use_lanes_ff ? lane_res[j] : 32'd0;
         end
      end
   end

   // joint lanes, one per configured joint; unused slots read as zero
   for (genvar g = 0; g < NJ; g++) begin : g_lane
      if (g < NUM_JOINTS) begin : g_on
         kti_lane #(
            .DEPTH  (DEPTH),
            .ADDR_W (ADDR_W)
         ) u_lane (
            .clock   (clock),
            .reset   (reset),
            .ctl     (lane_ctl),
            .addr    (addr),
            .wr_data (jin_ff[g]),
            .result  (lane_res[g]),
            .busy    (lane_busy[g])
         );
      end else begin : g_off
         assign lane_res[g]  = 32'd0;
         assign lane_busy[g] = 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_joint_0   = rsp_joint_ff[0];
   assign rsp_out_joint_1   = rsp_joint_ff[1];
   assign rsp_out_joint_2   = rsp_joint_ff[2];
   assign rsp_out_joint_3   = rsp_joint_ff[3];
   assign rsp_out_joint_4   = rsp_joint_ff[4];
   assign rsp_out_joint_5   = rsp_joint_ff[5];
   assign rsp_path_duration = rsp_dur_ff;

`ifndef ASSERT_OFF
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == kti_pkg::OP_CLEAR) |=> state_ff == S_DONE)
      else $error("clear transaction did not go straight to the result");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_rd) <= MAX_KEYFRAMES)
      else $error("keyframe count beyond table size");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SC_CMP && !(t_ff > s_now) && go_interp) |-> s_now != sp_ff)
      else $error("interpolation with zero segment length");

   a_lane_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LN_GO) |=> lane_busy_any || NUM_JOINTS == 0)
      else $error("lanes did not start");
`endif

endmodule
`default_nettype wire
